// ===== rtl/fwh_pkg.sv =====
// Shared types and constants of the full-width to half-width converter.
`default_nettype none
package fwh_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [7:0]  SPACE        = 8'h20;
  localparam logic [7:0]  GBK_LEAD_MIN = 8'hA1;
  localparam logic [3:0]  UTF_LEAD_HI  = 4'hE;
  localparam logic [15:0] GBK_IDSP     = 16'hA1A1;
  localparam logic [15:0] GBK_LO       = 16'hA3C1;
  localparam logic [15:0] GBK_HI       = 16'hA3FE;
  localparam logic [15:0] GBK_OFS      = 16'hA380;
  localparam logic [15:0] UTF_IDSP     = 16'h3000;
  localparam logic [15:0] UTF_LO       = 16'hFF01;
  localparam logic [15:0] UTF_HI       = 16'hFF5E;
  localparam logic [15:0] UTF_OFS      = 16'hFEE0;

  localparam logic [1:0] NONE_HELD = 2'd0;
  localparam logic [1:0] ONE_HELD  = 2'd1;
  localparam logic [1:0] TWO_HELD  = 2'd2;

  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/fwh_front.sv =====
// Front end: tracks held bytes and turns each finished sequence into an output command.
`default_nettype none
module fwh_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output fwh_pkg::cmd_t    cmd,
  output logic             cmd_push
);

  logic        code_mode;
  logic [1:0]  pend;
  logic [1:0]  pend_next;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic        hold0_wr;
  logic        hold1_wr;
  logic        lead;
  logic [15:0] code_g;
  logic [15:0] code_u;
  logic [15:0] diff_g;
  logic [15:0] diff_u;

  always_comb begin
    lead   = code_mode ? (in_byte >= fwh_pkg::GBK_LEAD_MIN)
                       : (in_byte[7:4] == fwh_pkg::UTF_LEAD_HI);
    code_g = {held0, in_byte};
    code_u = {held0[3:0], held1[5:0], in_byte[5:0]};
    diff_g = code_g - fwh_pkg::GBK_OFS;
    diff_u = code_u - fwh_pkg::UTF_OFS;
    pend_next = fwh_pkg::NONE_HELD;
    hold0_wr  = 1'b0;
    hold1_wr  = 1'b0;
    cmd_push  = 1'b0;
    cmd.count = 2'd1;
    cmd.bytes = {8'h00, 8'h00, in_byte};
    cmd.last  = in_last;
    priority if (pend == fwh_pkg::NONE_HELD) begin
      if (lead && !in_last) begin
        pend_next = fwh_pkg::ONE_HELD;
        hold0_wr  = 1'b1;
      end else begin
        cmd_push = 1'b1;
      end
    end else if (!code_mode && pend == fwh_pkg::ONE_HELD) begin
      if (!in_last) begin
        pend_next = fwh_pkg::TWO_HELD;
        hold1_wr  = 1'b1;
      end else begin
        cmd_push  = 1'b1;
        cmd.count = 2'd2;
        cmd.bytes = {8'h00, in_byte, held0};
      end
    end else if (code_mode) begin
      cmd_push = 1'b1;
      if (code_g == fwh_pkg::GBK_IDSP) begin
        cmd.bytes = {8'h00, 8'h00, fwh_pkg::SPACE};
      end else if (code_g >= fwh_pkg::GBK_LO && code_g <= fwh_pkg::GBK_HI) begin
        cmd.bytes = {8'h00, 8'h00, diff_g[7:0]};
      end else begin
        cmd.count = 2'd2;
        cmd.bytes = {8'h00, in_byte, held0};
      end
    end else begin
      cmd_push = 1'b1;
      if (code_u == fwh_pkg::UTF_IDSP) begin
        cmd.bytes = {8'h00, 8'h00, fwh_pkg::SPACE};
      end else if (code_u >= fwh_pkg::UTF_LO && code_u <= fwh_pkg::UTF_HI) begin
        cmd.bytes = {8'h00, 8'h00, diff_u[7:0]};
      end else begin
        cmd.count = 2'd3;
        cmd.bytes = {in_byte, held1, held0};
      end
    end
    cmd_push = cmd_push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_mode <= 1'b0;
      pend      <= fwh_pkg::NONE_HELD;
    end else if (cfg_we) begin
      code_mode <= cfg_data;
      pend      <= fwh_pkg::NONE_HELD;
    end else if (accept) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold0_wr) begin
      held0 <= in_byte;
    end
    if (accept && hold1_wr) begin
      held1 <= in_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fwh_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
module fwh_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fwh_pkg::cmd_t wdata,
  input  wire logic          pop,
  output fwh_pkg::cmd_t      rdata,
  output fwh_pkg::q_stat_t   stat
);

  fwh_pkg::cmd_t                  mem [fwh_pkg::QDEPTH];
  logic [fwh_pkg::QAW-1:0]        wr_ptr;
  logic [fwh_pkg::QAW-1:0]        rd_ptr;
  logic [fwh_pkg::QAW:0]          fill;

  assign stat.full  = (fill == (fwh_pkg::QAW+1)'(fwh_pkg::QDEPTH));
  assign stat.empty = (fill == '0);
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fwh_back.sv =====
// Back end: takes commands from the queue and presents their bytes one per transfer.
`default_nettype none
module fwh_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fwh_pkg::cmd_t    q_data,
  input  wire fwh_pkg::q_stat_t q_stat,
  output logic                  q_pop,
  input  wire logic             pop,
  output logic                  empty,
  output logic [7:0]            out_byte,
  output logic                  out_end,
  output logic                  out_run_last
);

  fwh_pkg::cmd_t cur;
  logic          cur_valid;
  logic [1:0]    idx;
  logic          at_end;

  assign at_end       = (idx == cur.count - 2'd1);
  assign q_pop        = !q_stat.empty && (!cur_valid || (pop && at_end));
  assign empty        = !cur_valid;
  assign out_byte     = cur.bytes[idx];
  assign out_run_last = at_end;
  assign out_end      = at_end && cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (pop && cur_valid) begin
      if (at_end) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fullwidth_to_halfwidth.sv =====
// Top level of the full-width to half-width text converter.
// One input byte is accepted per clock while full is low; a byte that only
// completes part of a multi-byte sequence produces no output. Each accepted
// byte that finishes a sequence places one command of one to three output
// bytes in a four-entry queue, and the output side delivers one byte per pop,
// so a command of k bytes holds the output side for k pops. Sustained
// throughput is therefore one byte per cycle at the input and one byte per
// cycle at the output while pop is held high, and neither side limits the
// other, as no sequence yields more output bytes than it took in. The mode
// register is written through the configuration channel, which is always
// ready, and a write drops any partially received sequence.
`default_nettype none
module fullwidth_to_halfwidth (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_end,
  output logic            out_run_last
);

  fwh_pkg::cmd_t    cmd;
  fwh_pkg::cmd_t    q_data;
  fwh_pkg::q_stat_t q_stat;
  logic             cmd_push;
  logic             q_pop;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign full      = q_stat.full;
  assign accept    = push && !q_stat.full;

  fwh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  fwh_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd),
    .pop   (q_pop),
    .rdata (q_data),
    .stat  (q_stat)
  );

  fwh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_data),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .out_end      (out_end),
    .out_run_last (out_run_last)
  );

endmodule
`default_nettype wire

// ===== rtl/fwh_checker.sv =====
// Port-level checker for the converter and the bind that attaches it.
`default_nettype none
module fwh_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_end,
  input wire logic       out_run_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_end)
                          && $stable(out_run_last)))
    else $error("result changed while stalled");

  a_end_in_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_end) |-> out_run_last)
    else $error("end of string outside the last byte of a run");

  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !out_run_last) |=> !empty)
    else $error("run of results broken before its last byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("results present or input blocked after reset");

endmodule

bind fullwidth_to_halfwidth fwh_checker u_fwh_checker (.*);
`default_nettype wire
